// ----- design/tlvp_pkg.sv -----
// Package for the TLV option parser: request and result types, phase and code enums,
// and the option kind decoder.
// No dependencies; every module of the parser imports it.
`default_nettype none

package tlvp_pkg;

    // Generic payloads longer than this are rejected at the length byte.
    localparam logic [7:0] MAX_PAYLOAD = 8'd253;

    // Required lengths of the fixed options and bytes taken by complete options.
    localparam logic [7:0] CHAIN_LEN  = 8'd2;
    localparam logic [7:0] SEV_LEN    = 8'd1;
    localparam logic [7:0] USED_NOP   = 8'd1;
    localparam logic [7:0] USED_HDR   = 8'd2;
    localparam logic [7:0] USED_SEV   = 8'd3;
    localparam logic [7:0] USED_CHAIN = 8'd4;

    // Configuration register indexes and reset values.
    localparam int unsigned CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_CHAIN_CODE = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_SEV_CODE   = 1'b1;
    localparam logic [7:0] CHAIN_CODE_RST = 8'd1;
    localparam logic [7:0] SEV_CODE_RST   = 8'd2;

    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_LEN     = 3'd1,
        PH_CHAIN   = 3'd2,
        PH_SEV     = 3'd3,
        PH_ANY     = 3'd4,
        PH_DISCARD = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NOP   = 2'd0,
        KIND_CHAIN = 2'd1,
        KIND_SEV   = 2'd2,
        KIND_ANY   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD = 2'd0,
        EV_DONE    = 2'd1,
        EV_ERROR   = 2'd2
    } event_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [1:0]  option_kind;
        logic [7:0]  option_type;
        logic [7:0]  option_length;
        logic [15:0] chain_value;
        logic [2:0]  severity_level;
        logic        payload_valid;
        logic [7:0]  payload_out;
        logic [7:0]  bytes_consumed;
    } out_item_t;

    // Request held in the input register.
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } in_slot_t;

    // Result produced by the parser core for the output register.
    typedef struct packed {
        logic      valid;
        out_item_t item;
    } res_slot_t;

    // Kind of an option type byte; the chain code wins over the severity code.
    function automatic kind_t kind_of(input logic [7:0] t, input logic [7:0] chain_code,
                                      input logic [7:0] sev_code);
        kind_t k;
        if (t == 8'd0) begin
            k = KIND_NOP;
        end else if (t == chain_code) begin
            k = KIND_CHAIN;
        end else if (t == sev_code) begin
            k = KIND_SEV;
        end else begin
            k = KIND_ANY;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ----- design/tlv_option_parser.sv -----
// Top level of the TLV option parser: configuration registers and the three stages.
// Depends on tlvp_pkg, tlvp_in_stage, tlvp_core and tlvp_out_stage.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one byte of the option area
//   per request, with buffer_end set on the last byte of a buffer.
//   Output channel (out_valid / out_stall / out_data) carries zero or one result per
//   byte: a generic payload byte, a completed option or an error.
//   A request is registered in the input register, parsed by the core and its result
//   lands in the output register, whose valid bit drives out_valid to the receiver.
//   One byte per cycle is sustained while the receiver does not stall; the rate is set
//   by the single parse step between the input and output registers.
//   When the receiver stalls, the output register holds its result and the input
//   register holds at most one more byte, after which in_stall rises.
//   Reset empties both registers, returns the parser to waiting for a type byte and
//   loads the chain code with 1 and the severity code with 2. The user writes the codes
//   on cfg_we / cfg_index / cfg_data with no byte in flight; the block does not check.
`default_nettype none

module tlv_option_parser (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire tlvp_pkg::in_item_t                   in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output tlvp_pkg::out_item_t                       out_data,
    input  wire logic                                 cfg_we,
    input  wire logic [tlvp_pkg::CfgIdxW-1:0]         cfg_index,
    input  wire logic [7:0]                           cfg_data
);
    import tlvp_pkg::*;

    logic [7:0] chain_code_reg;
    logic [7:0] sev_code_reg;
    in_slot_t   slot;
    res_slot_t  res;
    logic       proc;
    logic       slot_free;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_code_reg <= CHAIN_CODE_RST;
            sev_code_reg   <= SEV_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CHAIN_CODE: chain_code_reg <= cfg_data;
                CFG_SEV_CODE:   sev_code_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    tlvp_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .proc     (proc),
        .slot     (slot)
    );

    tlvp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot       (slot),
        .slot_free  (slot_free),
        .chain_code (chain_code_reg),
        .sev_code   (sev_code_reg),
        .proc       (proc),
        .res        (res)
    );

    tlvp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .proc      (proc),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ----- design/tlvp_in_stage.sv -----
// Input register of the TLV option parser: holds one request until the core takes it.
// Depends on tlvp_pkg.
`default_nettype none

module tlvp_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire tlvp_pkg::in_item_t in_data,
    input  wire logic              proc,
    output tlvp_pkg::in_slot_t     slot
);
    import tlvp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     take;

    // The register can take a new request when it is empty or drains this cycle.
    assign in_stall   = valid_reg & ~proc;
    assign take       = in_valid & ~in_stall;
    assign valid_next = take | (valid_reg & ~proc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_data;
        end
    end

    assign slot.valid = valid_reg;
    assign slot.item  = item_reg;

endmodule

`default_nettype wire

// ----- design/tlvp_core.sv -----
// Parser core of the TLV option parser: parse state registers and the per-byte logic
// that updates them and forms the result. Depends on tlvp_pkg.
`default_nettype none

module tlvp_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire tlvp_pkg::in_slot_t slot,
    input  wire logic               slot_free,
    input  wire logic [7:0]         chain_code,
    input  wire logic [7:0]         sev_code,
    output logic                    proc,
    output tlvp_pkg::res_slot_t     res
);
    import tlvp_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] type_reg;
    logic [7:0] type_next;
    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic [7:0] left_reg;
    logic [7:0] left_next;
    logic [7:0] idhi_reg;
    logic [7:0] idhi_next;

    logic [7:0] b;
    logic       last;
    kind_t      held_kind;
    kind_t      new_kind;
    phase_t     fail_phase;
    logic       has_res;
    out_item_t  r;

    // The byte is parsed once the output register has room for its result.
    assign proc       = slot.valid & slot_free;
    assign b          = slot.item.data_byte;
    assign last       = slot.item.buffer_end;
    assign held_kind  = kind_of(type_reg, chain_code, sev_code);
    assign new_kind   = kind_of(b, chain_code, sev_code);
    assign fail_phase = last ? PH_TYPE : PH_DISCARD;

    // Next parse state.
    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        idhi_next  = idhi_reg;
        unique case (phase_reg)
            PH_LEN:
            begin
                len_next = b;
                if (held_kind == KIND_CHAIN)
                begin
                    if (b != CHAIN_LEN || last)
                    begin
                        phase_next = fail_phase;
                    end
                    else
                    begin
                        left_next  = CHAIN_LEN;
                        phase_next = PH_CHAIN;
                    end
                end
                else if (held_kind == KIND_SEV)
                begin
                    if (b != SEV_LEN || last)
                    begin
                        phase_next = fail_phase;
                    end
                    else
                    begin
                        left_next  = SEV_LEN;
                        phase_next = PH_SEV;
                    end
                end
                else if (b > MAX_PAYLOAD)
                begin
                    phase_next = fail_phase;
                end
                else if (b == 8'd0)
                begin
                    phase_next = PH_TYPE;
                end
                else if (last)
                begin
                    phase_next = fail_phase;
                end
                else
                begin
                    left_next  = b;
                    phase_next = PH_ANY;
                end
            end
            PH_CHAIN:
            begin
                left_next = left_reg - 8'd1;
                idhi_next = b;
                if (left_reg == 8'd1)
                begin
                    phase_next = PH_TYPE;
                end
                else if (last)
                begin
                    phase_next = fail_phase;
                end
            end
            PH_SEV:
            begin
                left_next  = 8'd0;
                phase_next = PH_TYPE;
            end
            PH_ANY:
            begin
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                begin
                    phase_next = PH_TYPE;
                end
                else if (last)
                begin
                    phase_next = fail_phase;
                end
            end
            PH_DISCARD:
            begin
                if (last)
                begin
                    phase_next = PH_TYPE;
                end
            end
            default:
            begin
                // Type byte; unused phase codes land here as well.
                type_next = b;
                len_next  = 8'd0;
                left_next = 8'd0;
                if (b == 8'd0 || last)
                begin
                    phase_next = PH_TYPE;
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end
        endcase
    end

    // Result for the current byte.
    always_comb
    begin
        has_res          = 1'b0;
        r.event_res      = EV_ERROR;
        r.option_kind    = KIND_ANY;
        r.option_type    = type_reg;
        r.option_length  = len_reg;
        r.chain_value    = 16'd0;
        r.severity_level = 3'd0;
        r.payload_valid  = 1'b0;
        r.payload_out    = 8'd0;
        r.bytes_consumed = 8'd0;
        unique case (phase_reg)
            PH_LEN:
            begin
                r.option_kind   = held_kind;
                r.option_length = b;
                if (held_kind == KIND_CHAIN)
                begin
                    has_res = (b != CHAIN_LEN) || last;
                end
                else if (held_kind == KIND_SEV)
                begin
                    has_res = (b != SEV_LEN) || last;
                end
                else if (b > MAX_PAYLOAD)
                begin
                    has_res = 1'b1;
                end
                else if (b == 8'd0)
                begin
                    // An empty generic option completes at its length byte.
                    has_res          = 1'b1;
                    r.event_res      = EV_DONE;
                    r.bytes_consumed = USED_HDR;
                end
                else
                begin
                    has_res = last;
                end
            end
            PH_CHAIN:
            begin
                r.option_kind = KIND_CHAIN;
                if (left_reg == 8'd1)
                begin
                    has_res          = 1'b1;
                    r.event_res      = EV_DONE;
                    r.chain_value    = {idhi_reg, b};
                    r.bytes_consumed = USED_CHAIN;
                end
                else
                begin
                    has_res = last;
                end
            end
            PH_SEV:
            begin
                has_res          = 1'b1;
                r.event_res      = EV_DONE;
                r.option_kind    = KIND_SEV;
                r.severity_level = b[2:0];
                r.bytes_consumed = USED_SEV;
            end
            PH_ANY:
            begin
                if (left_reg == 8'd1)
                begin
                    has_res          = 1'b1;
                    r.event_res      = EV_DONE;
                    r.payload_valid  = 1'b1;
                    r.payload_out    = b;
                    r.bytes_consumed = len_reg + USED_HDR;
                end
                else if (last)
                begin
                    has_res = 1'b1;
                end
                else
                begin
                    has_res         = 1'b1;
                    r.event_res     = EV_PAYLOAD;
                    r.payload_valid = 1'b1;
                    r.payload_out   = b;
                end
            end
            PH_DISCARD:
            begin
                has_res = 1'b0;
            end
            default:
            begin
                r.option_type   = b;
                r.option_length = 8'd0;
                if (b == 8'd0)
                begin
                    has_res          = 1'b1;
                    r.event_res      = EV_DONE;
                    r.option_kind    = KIND_NOP;
                    r.bytes_consumed = USED_NOP;
                end
                else
                begin
                    // Buffer ends right after the type byte.
                    has_res       = last;
                    r.option_kind = new_kind;
                end
            end
        endcase
    end

    assign res.valid = proc & has_res;
    assign res.item  = r;

    // Parse state advances only on a parsed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            type_reg  <= 8'd0;
            len_reg   <= 8'd0;
            left_reg  <= 8'd0;
            idhi_reg  <= 8'd0;
        end
        else if (proc)
        begin
            phase_reg <= phase_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            idhi_reg  <= idhi_next;
        end
    end

    // A passed-out payload byte always belongs to a generic option.
    a_payload_generic: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.item.payload_valid |-> res.item.option_kind == KIND_ANY)
        else $error("payload byte passed out for a non-generic option");

    // Errors never report consumed bytes or data.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.item.event_res == EV_ERROR
        |-> res.item.bytes_consumed == 8'd0 && !res.item.payload_valid
            && res.item.chain_value == 16'd0)
        else $error("error result carries data");

    // While in a body phase there is always at least one byte left.
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ANY || phase_reg == PH_CHAIN |-> left_reg != 8'd0)
        else $error("body phase with no bytes left");

    // The parse state holds while no byte is parsed.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !proc |=> $stable(phase_reg) && $stable(left_reg))
        else $error("parse state moved without a parsed byte");

endmodule

`default_nettype wire

// ----- design/tlvp_out_stage.sv -----
// Output register of the TLV option parser: holds one result until the receiver takes it.
// Depends on tlvp_pkg.
`default_nettype none

module tlvp_out_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                proc,
    input  wire tlvp_pkg::res_slot_t res,
    output logic                     slot_free,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output tlvp_pkg::out_item_t      out_data
);
    import tlvp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // Room for a new result when empty or when the held one leaves this cycle.
    assign slot_free  = ~valid_reg | ~out_stall;
    assign valid_next = proc ? res.valid : (valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && res.valid)
        begin
            item_reg <= res.item;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = item_reg;

endmodule

`default_nettype wire

// ----- tb/tlv_option_checker.sv -----
// Checker for the TLV option parser: watches both channels and the code register port,
// predicts every parser result and compares it field by field.
// Depends on tlvp_pkg for the request, result, phase and kind types.
`timescale 1ns / 1ps

module tlv_option_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_stall,
    input  wire tlvp_pkg::in_item_t           in_data,
    input  wire logic                         out_valid,
    input  wire logic                         out_stall,
    input  wire tlvp_pkg::out_item_t          out_data,
    input  wire logic                         cfg_we,
    input  wire logic [tlvp_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [7:0]                   cfg_data,
    output int                                error_count,
    output int                                events_due,
    output int                                results_seen
);
    import tlvp_pkg::*;

    // Shadow of the parser state and of the two type-code registers.
    phase_t      phase;
    logic [7:0]  held_type;
    logic [7:0]  held_length;
    logic [7:0]  bytes_left;
    logic [15:0] id_acc;
    logic [7:0]  chain_code;
    logic [7:0]  sev_code;

    // Results predicted but not yet delivered, oldest first.
    out_item_t   parsed_events[$];
    out_item_t   oldest;

    // Type zero is always a no-op; the chain code wins when both codes match.
    function automatic kind_t classify_type(input logic [7:0] t);
        kind_t k;
        if (t == 8'd0) begin
            k = KIND_NOP;
        end else if (t == chain_code) begin
            k = KIND_CHAIN;
        end else if (t == sev_code) begin
            k = KIND_SEV;
        end else begin
            k = KIND_ANY;
        end
        return k;
    endfunction

    // A result carrying the held type with every value field cleared.
    function automatic out_item_t make_event(input event_t ev, input kind_t kind,
                                             input logic [7:0] len);
        out_item_t r;
        r = '0;
        r.event_res     = ev;
        r.option_kind   = kind;
        r.option_type   = held_type;
        r.option_length = len;
        return r;
    endfunction

    // An error reports what was received so far; off a buffer end the rest is dropped.
    task option_error(input kind_t kind, input logic last);
        parsed_events.push_back(make_event(EV_ERROR, kind, held_length));
        phase = last ? PH_TYPE : PH_DISCARD;
    endtask

    // Advance the shadow parser by one request and queue the result it causes.
    task parse_option_byte(input in_item_t req);
        logic [7:0] b;
        logic       last;
        kind_t      kind;
        out_item_t  r;
        b    = req.data_byte;
        last = req.buffer_end;
        case (phase)
            PH_LEN:
            begin
                kind        = classify_type(held_type);
                held_length = b;
                if (kind == KIND_CHAIN) begin
                    if (b != CHAIN_LEN || last) begin
                        option_error(kind, last);
                    end else begin
                        bytes_left = CHAIN_LEN;
                        id_acc     = '0;
                        phase      = PH_CHAIN;
                    end
                end else if (kind == KIND_SEV) begin
                    if (b != SEV_LEN || last) begin
                        option_error(kind, last);
                    end else begin
                        bytes_left = SEV_LEN;
                        phase      = PH_SEV;
                    end
                end else if (b > MAX_PAYLOAD) begin
                    option_error(kind, last);
                end else if (b == 8'd0) begin
                    // An empty generic option completes on its length byte.
                    r = make_event(EV_DONE, kind, 8'd0);
                    r.bytes_consumed = USED_HDR;
                    parsed_events.push_back(r);
                    phase = PH_TYPE;
                end else if (last) begin
                    option_error(kind, last);
                end else begin
                    bytes_left = b;
                    phase      = PH_ANY;
                end
            end
            PH_CHAIN:
            begin
                // The id arrives most significant byte first.
                id_acc     = {id_acc[7:0], b};
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) begin
                    r = make_event(EV_DONE, KIND_CHAIN, held_length);
                    r.chain_value    = id_acc;
                    r.bytes_consumed = USED_CHAIN;
                    parsed_events.push_back(r);
                    phase = PH_TYPE;
                end else if (last) begin
                    option_error(KIND_CHAIN, last);
                end
            end
            PH_SEV:
            begin
                bytes_left = 8'd0;
                r = make_event(EV_DONE, KIND_SEV, held_length);
                r.severity_level = b[2:0];
                r.bytes_consumed = USED_SEV;
                parsed_events.push_back(r);
                phase = PH_TYPE;
            end
            PH_ANY:
            begin
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) begin
                    r = make_event(EV_DONE, KIND_ANY, held_length);
                    r.payload_valid  = 1'b1;
                    r.payload_out    = b;
                    r.bytes_consumed = USED_HDR + held_length;
                    parsed_events.push_back(r);
                    phase = PH_TYPE;
                end else if (last) begin
                    // The payload byte that meets the buffer end is not passed out.
                    option_error(KIND_ANY, last);
                end else begin
                    r = make_event(EV_PAYLOAD, KIND_ANY, held_length);
                    r.payload_valid = 1'b1;
                    r.payload_out   = b;
                    parsed_events.push_back(r);
                end
            end
            PH_DISCARD:
            begin
                if (last) begin
                    phase = PH_TYPE;
                end
            end
            default:
            begin
                // Waiting for a type byte; unused phase codes behave the same way.
                held_type   = b;
                held_length = 8'd0;
                bytes_left  = 8'd0;
                if (b == 8'd0) begin
                    r = make_event(EV_DONE, KIND_NOP, 8'd0);
                    r.bytes_consumed = USED_NOP;
                    parsed_events.push_back(r);
                    phase = PH_TYPE;
                end else if (last) begin
                    option_error(classify_type(b), last);
                end else begin
                    phase = PH_LEN;
                end
            end
        endcase
    endtask

    // Compare one result field and count a mismatch.
    task check_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Results are compared before the request of the same edge is predicted, since a
    // result never belongs to the request accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase        = PH_TYPE;
            held_type    = '0;
            held_length  = '0;
            bytes_left   = '0;
            id_acc       = '0;
            chain_code   = CHAIN_CODE_RST;
            sev_code     = SEV_CODE_RST;
            parsed_events.delete();
            error_count  = 0;
            results_seen = 0;
            events_due  <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_CHAIN_CODE) begin
                    chain_code = cfg_data;
                end else begin
                    sev_code = cfg_data;
                end
            end
            if (out_valid && !out_stall) begin
                results_seen++;
                if (parsed_events.size() == 0) begin
                    $error("result with no prediction waiting: %h", out_data);
                    error_count++;
                end else begin
                    oldest = parsed_events.pop_front();
                    check_field("event_res", 16'(oldest.event_res),
                                16'(out_data.event_res));
                    check_field("option_kind", 16'(oldest.option_kind),
                                16'(out_data.option_kind));
                    check_field("option_type", 16'(oldest.option_type),
                                16'(out_data.option_type));
                    check_field("option_length", 16'(oldest.option_length),
                                16'(out_data.option_length));
                    check_field("chain_value", oldest.chain_value, out_data.chain_value);
                    check_field("severity_level", 16'(oldest.severity_level),
                                16'(out_data.severity_level));
                    check_field("payload_valid", 16'(oldest.payload_valid),
                                16'(out_data.payload_valid));
                    check_field("payload_out", 16'(oldest.payload_out),
                                16'(out_data.payload_out));
                    check_field("bytes_consumed", 16'(oldest.bytes_consumed),
                                16'(out_data.bytes_consumed));
                end
            end
            if (in_valid && !in_stall) begin
                parse_option_byte(in_data);
            end
            events_due <= parsed_events.size();
        end
    end

endmodule

// ----- tb/tlv_option_parser_test.sv -----
// Top of the TLV option parser testbench: clock, reset, option byte stream and verdict.
// Depends on tlvp_pkg, the parser top level and tlv_option_checker.
`timescale 1ns / 1ps

module tlv_option_parser_test;
    import tlvp_pkg::*;

    localparam int RANDOM_BYTES  = 1875;
    localparam int SEGMENTS      = 6;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 4000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_item_t             in_data;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we;
    logic [CfgIdxW-1:0]   cfg_index;
    logic [7:0]           cfg_data;

    int                   mismatches;
    int                   events_due;
    int                   results_seen;
    int                   send_idle_pct = 19;
    int                   stall_pct = 58;
    int                   bytes_sent = 0;
    int                   quiet_cycles = 0;
    logic [7:0]           chain_code_now;
    logic [7:0]           sev_code_now;

    tlv_option_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tlv_option_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_count  (mismatches),
        .events_due   (events_due),
        .results_seen (results_seen)
    );

    // 20 ns clock.
    always #10 clk = ~clk;

    // Receiver stalls at random.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: too long without any request or result accepted ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request after a random idle gap and wait until it is accepted.
    task push_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, last};
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Hold off the sender until every predicted result has come out.
    task wait_idle;
        in_valid <= 1'b0;
        @(posedge clk);
        while (events_due != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both type-code registers on consecutive cycles.
    task write_codes(input logic [7:0] chain, input logic [7:0] sev);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CHAIN_CODE;
        cfg_data  <= chain;
        @(posedge clk);
        cfg_index <= CFG_SEV_CODE;
        cfg_data  <= sev;
        @(posedge clk);
        cfg_we    <= 1'b0;
        chain_code_now = chain;
        sev_code_now   = sev;
    endtask

    // Buffer end inside an option is rare; after a complete option it is common.
    function automatic logic body_end();
        return ($urandom_range(199) == 0);
    endfunction

    function automatic logic tail_end();
        return ($urandom_range(99) < 10);
    endfunction

    // One option with random content; a broken one is closed by a buffer-end byte so
    // that little of the stream is dropped.
    task send_option(input bit longest);
        int         pick;
        int         len;
        int         i;
        logic [7:0] t;
        pick = longest ? 50 : $urandom_range(99);
        if (pick < 8) begin
            push_byte(8'h00, tail_end());
        end else if (pick < 28) begin
            push_byte(chain_code_now, body_end());
            if ($urandom_range(9) == 0) begin
                do len = $urandom_range(255); while (len == CHAIN_LEN);
                push_byte(len[7:0], body_end());
                push_byte(8'($urandom_range(255)), 1'b1);
            end else begin
                push_byte(CHAIN_LEN, body_end());
                push_byte(8'($urandom_range(255)), body_end());
                push_byte(8'($urandom_range(255)), tail_end());
            end
        end else if (pick < 46) begin
            push_byte(sev_code_now, body_end());
            if ($urandom_range(9) == 0) begin
                do len = $urandom_range(255); while (len == SEV_LEN);
                push_byte(len[7:0], body_end());
                push_byte(8'($urandom_range(255)), 1'b1);
            end else begin
                // With equal codes this becomes a bad chain option, so close the buffer.
                push_byte(SEV_LEN, body_end());
                push_byte(8'($urandom_range(255)),
                          (sev_code_now == chain_code_now) ? 1'b1 : tail_end());
            end
        end else if (pick < 90) begin
            do t = 8'($urandom_range(1, 255)); while (t == chain_code_now || t == sev_code_now);
            len = $urandom_range(999);
            if (longest || len < 8) begin
                len = int'(MAX_PAYLOAD);
            end else if (len < 30) begin
                len = $urandom_range(MAX_PAYLOAD + 1, 255);
            end else if (len < 200) begin
                len = $urandom_range(7, 40);
            end else begin
                len = $urandom_range(0, 6);
            end
            push_byte(t, body_end());
            if (len > MAX_PAYLOAD) begin
                push_byte(len[7:0], body_end());
                push_byte(8'($urandom_range(255)), 1'b1);
            end else begin
                push_byte(len[7:0], (len == 0) ? tail_end() : body_end());
                for (i = 1; i <= len; i++) begin
                    push_byte(8'($urandom_range(255)), (i == len) ? tail_end() : body_end());
                end
            end
        end else begin
            // Noise: a few arbitrary bytes, then a buffer end.
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++) begin
                push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            push_byte(8'($urandom_range(255)), 1'b1);
        end
    endtask

    initial
    begin
        int          seg;
        int          target;
        logic [15:0] codes;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        chain_code_now = CHAIN_CODE_RST;
        sev_code_now   = SEV_CODE_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed stream under the reset codes: no-op, chain id, severity, empty and
        // short generic options, then a wrong chain length followed by dropped bytes,
        // an oversize length on a buffer end, a type byte alone and a truncated payload.
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b0);
        push_byte(8'hAB, 1'b0); push_byte(8'hCD, 1'b0);
        push_byte(8'h02, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(8'h80, 1'b0); push_byte(8'h02, 1'b0);
        push_byte(8'h55, 1'b0); push_byte(8'hAA, 1'b0);
        push_byte(8'h01, 1'b0); push_byte(8'h03, 1'b0);
        push_byte(8'h11, 1'b0); push_byte(8'h22, 1'b1);
        push_byte(8'h40, 1'b0); push_byte(8'hFE, 1'b1);
        push_byte(8'h33, 1'b1);
        push_byte(8'h44, 1'b0); push_byte(8'h03, 1'b0);
        push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b1);

        // Random options in segments, each under its own pair of type codes; the
        // sender idles lightly and the receiver heavily, then the reverse, then neither.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            wait_idle;
            send_idle_pct = (seg < 2) ? 19 : (seg < 4) ? 58 : 0;
            stall_pct     = (seg < 2) ? 58 : (seg < 4) ? 19 : 0;
            case (seg)
                0:       codes = {8'd255, 8'd1};
                1:       codes = {8'd9, 8'd9};
                2:       codes = {8'd1, 8'd255};
                3:       codes = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
                4:       codes = {8'd255, 8'd255};
                default: codes = {8'd128, 8'd3};
            endcase
            write_codes(codes[15:8], codes[7:0]);
            if (seg == 0 || seg == SEGMENTS - 1) begin
                send_option(1'b1);
            end
            target = 25 + (seg + 1) * RANDOM_BYTES / SEGMENTS;
            while (bytes_sent < target) begin
                send_option(1'b0);
                if ($urandom_range(59) == 0) begin
                    wait_idle;
                end
            end
        end
        wait_idle;

        $display("Streamed %0d option bytes under %0d type-code settings, with idling on",
                 bytes_sent, SEGMENTS + 1);
        $display("either side and none; %0d parser results compared, %0d mismatches.",
                 results_seen, mismatches);
        if (mismatches == 0 && events_due == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
